// ===== hdl/ptts_pkg.sv =====
// Shared constants, field widths, codes and types of the periodic task tick scheduler.
`default_nettype none
package ptts_pkg;

  localparam int PRIORITIES = 4;
  localparam int SLOTS      = 8;
  localparam int ENTRIES    = PRIORITIES * SLOTS;

  localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PRIO_W = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int PCNT_W = $clog2(PRIORITIES + 1);

  localparam int OP_W    = 2;
  localparam int PRIOF_W = 2;
  localparam int ID_W    = 16;
  localparam int PER_W   = 8;
  localparam int KIND_W  = 2;
  localparam int RSLOT_W = 3;
  localparam int TICK_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISPATCH = 2'd0,
    KIND_END      = 2'd1,
    KIND_CREATE   = 2'd2,
    KIND_DELETE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_READY = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_DEL   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] timeout;
    mode_t            mode;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    opcode_t            opcode;
    logic [PRIOF_W-1:0] prio;
    logic [ID_W-1:0]    task_id;
    logic [PER_W-1:0]   period;
  } req_t;

  typedef struct packed {
    kind_t              kind;
    logic               ok;
    logic [ID_W-1:0]    run_id;
    logic [PRIOF_W-1:0] run_prio;
    logic [RSLOT_W-1:0] run_slot;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/ptts_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptts_core.sv =====
// Request sequencer: table walk with read-modify-write of the entry RAM and result issue.
`default_nettype none
module ptts_core import ptts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output res_t                   res,
  output logic                   ram_re,
  output logic      [ADDR_W-1:0] ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata,
  output logic                   ram_we,
  output logic      [ADDR_W-1:0] ram_waddr,
  output logic      [ENTRY_W-1:0] ram_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_RESP} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    level_cnt_r [PRIORITIES];
  logic [CNT_W-1:0]    level_cnt_nxt [PRIORITIES];
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [PCNT_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]    s_r, s_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pa_r, pa_nxt;
  logic [PRIOF_W-1:0]  pp_r, pp_nxt;
  logic [RSLOT_W-1:0]  ps_r, ps_nxt;
  logic                del_r, del_nxt;
  logic [ID_W-1:0]     del_id_r, del_id_nxt;
  res_t                resp_r, resp_nxt;

  entry_t              ent, upd;
  logic                emit, stall, p_done, prio_ok;
  logic [CNT_W-1:0]    cur_cnt, req_cnt;
  logic [PRIO_W-1:0]   req_pidx;
  res_t                disp;

  assign req_pidx = PRIO_W'(req.prio);
  assign prio_ok  = int'(req.prio) < PRIORITIES;
  assign req_cnt  = level_cnt_r[req_pidx];
  assign p_done   = int'(p_r) >= PRIORITIES;
  assign cur_cnt  = level_cnt_r[p_r[PRIO_W-1:0]];
  assign ent      = entry_t'(ram_rdata);

  always_comb begin
    upd  = ent;
    emit = 1'b0;
    if (del_r) begin
      if (ent.id == del_id_r) begin
        upd.id   = '0;
        upd.mode = MODE_DEL;
      end
    end else begin
      unique case (ent.mode)
        MODE_INIT: begin
          if ({1'b0, ent.period} == ({1'b0, tick_r} + 9'd1)) begin
            upd.mode = MODE_READY;
          end
        end
        MODE_READY: begin
          if (ent.id != '0) begin
            emit = 1'b1;
            if (ent.period != PER_W'(1)) begin
              upd.mode    = MODE_WAIT;
              upd.timeout = ent.period;
            end
          end
        end
        MODE_WAIT: begin
          if (ent.timeout > PER_W'(1)) begin
            upd.timeout = ent.timeout - PER_W'(1);
          end else begin
            upd.mode = MODE_READY;
          end
        end
        MODE_DEL: begin
          upd = ent;
        end
        default: upd = ent;
      endcase
    end
  end

  assign stall = pend_r && emit && !res_ready;

  always_comb begin
    disp          = '0;
    disp.kind     = KIND_DISPATCH;
    disp.run_id   = ent.id;
    disp.run_prio = pp_r;
    disp.run_slot = ps_r;
  end

  assign req_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    level_cnt_nxt = level_cnt_r;
    tick_nxt      = tick_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    pend_nxt      = pend_r;
    pa_nxt        = pa_r;
    pp_nxt        = pp_r;
    ps_nxt        = ps_r;
    del_nxt       = del_r;
    del_id_nxt    = del_id_r;
    resp_nxt      = resp_r;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(int'(p_r) * SLOTS + int'(s_r));
    ram_we        = 1'b0;
    ram_waddr     = pa_r;
    ram_wdata     = ENTRY_W'(upd);
    res_valid     = 1'b0;
    res           = disp;

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          resp_nxt          = '0;
          resp_nxt.last     = 1'b1;
          resp_nxt.run_prio = req.prio;
          p_nxt             = '0;
          s_nxt             = '0;
          pend_nxt          = 1'b0;
          del_id_nxt        = req.task_id;
          unique case (req.opcode)
            OP_TICK: begin
              tick_nxt          = tick_r + TICK_W'(1);
              resp_nxt.kind     = KIND_END;
              resp_nxt.run_prio = '0;
              del_nxt           = 1'b0;
              state_nxt         = ST_WALK;
            end
            OP_CREATE: begin
              resp_nxt.kind = KIND_CREATE;
              state_nxt     = ST_RESP;
              if (prio_ok && int'(req_cnt) < SLOTS) begin
                ram_we                  = 1'b1;
                ram_waddr               = ADDR_W'(int'(req.prio) * SLOTS + int'(req_cnt));
                ram_wdata               = ENTRY_W'({req.task_id, req.period, PER_W'(0),
                                                    MODE_INIT});
                level_cnt_nxt[req_pidx] = req_cnt + CNT_W'(1);
                resp_nxt.ok             = 1'b1;
                resp_nxt.run_slot       = RSLOT_W'(req_cnt);
              end
            end
            OP_DELETE: begin
              resp_nxt.kind = KIND_DELETE;
              if (prio_ok && req.task_id != '0) begin
                resp_nxt.ok = 1'b1;
                p_nxt       = PCNT_W'(req.prio);
                del_nxt     = 1'b1;
                state_nxt   = ST_WALK;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            OP_NONE: begin
              state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        res_valid = pend_r && emit;
        if (!stall) begin
          ram_we = pend_r;
          if (p_done) begin
            pend_nxt  = 1'b0;
            state_nxt = ST_RESP;
          end else if (s_r < cur_cnt) begin
            ram_re   = 1'b1;
            pend_nxt = 1'b1;
            pa_nxt   = ram_raddr;
            pp_nxt   = PRIOF_W'(p_r);
            ps_nxt   = RSLOT_W'(s_r);
            s_nxt    = s_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
            s_nxt    = '0;
            p_nxt    = del_r ? PCNT_W'(PRIORITIES) : p_r + PCNT_W'(1);
          end
        end
      end
      ST_RESP: begin
        res_valid = 1'b1;
        res       = resp_r;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_cnt_r <= '{default: '0};
      tick_r      <= '0;
      pend_r      <= 1'b0;
      del_r       <= 1'b0;
      p_r         <= '0;
      s_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      level_cnt_r <= level_cnt_nxt;
      tick_r      <= tick_nxt;
      pend_r      <= pend_nxt;
      del_r       <= del_nxt;
      p_r         <= p_nxt;
      s_r         <= s_nxt;
    end
    pa_r     <= pa_nxt;
    pp_r     <= pp_nxt;
    ps_r     <= ps_nxt;
    del_id_r <= del_id_nxt;
    resp_r   <= resp_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler: entry RAM, sequencer and output register.
//
// Tasks live in a table of PRIORITIES levels by SLOTS slots held in one RAM with a
// registered read. A tick request walks the occupied slots one per cycle, levels in
// order, while the result side does not stall on a dispatch, with the read of the next
// slot overlapping the write back of the current one. A delete walks only its own level.
// A create, or a rejected delete, skips the walk and goes straight to its result.
// Opcode 3 is accepted and dropped. Results pass through an output register, so a
// finished result may wait on out_tready while the sequencer carries on. No clearing
// pass is needed after reset.
`default_nettype none
module periodic_task_tick_scheduler import ptts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // prio[1:0], task_id[17:2], period[25:18], zero
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // ok[0], run_id[16:1], run_prio[18:17],
                                       // run_slot[21:19], zero
  output logic [1:0]       out_tuser,  // kind[1:0]
  output logic             out_tlast   // last
);

  req_t                req;
  res_t                res, out_r;
  logic                res_valid, res_ready, out_valid_r;
  logic                ram_re, ram_we;
  logic [ADDR_W-1:0]   ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0]  ram_rdata, ram_wdata;

  assign req.opcode  = opcode_t'(in_tuser);
  assign req.prio    = in_tdata[1:0];
  assign req.task_id = in_tdata[17:2];
  assign req.period  = in_tdata[25:18];

  ptts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.run_slot, out_r.run_prio, out_r.run_id, out_r.ok};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule
`default_nettype wire

// ===== hdl/ptts_checker.sv =====
// Port-level assertions of the periodic task tick scheduler and their bind.
`default_nettype none
module ptts_checker import ptts_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_NONE |=> !in_tready)
    else $error("new request taken while one is in progress");

  a_dispatch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DISPATCH |-> !out_tlast && !out_tdata[0]
      && out_tdata[16:1] != 16'd0)
    else $error("malformed dispatch result");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DISPATCH |-> out_tlast
      && (out_tuser != KIND_END || out_tdata == 24'd0))
    else $error("malformed closing result");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
